// ===== rtl/rrar_pkg.sv =====
// Shared types and constants for the remote RAM access responder.
// No dependencies; imported by rrar_engine and remote_ram_access_responder.
`default_nettype none

package rrar_pkg;

    // request kinds
    localparam logic [2:0] CMD_SPECIAL = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_WRITE   = 3'd2;
    localparam logic [2:0] CMD_PING    = 3'd3;

    // acknowledge kinds
    localparam logic [1:0] KIND_OK    = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam int unsigned ADDR_W = 17;          // 16-bit start plus byte offset
    localparam logic [15:0] ENS_SELECT = 16'hff00;
    localparam logic [3:0]  NBYTES = 4'd8;

    // version 1, "SID ", node version 2, subversion 0
    localparam logic [63:0] PING_BYTES = 64'h0000_0220_4449_5301;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  requester;
        logic [15:0] control;
        logic [63:0] payload;
        logic [3:0]  length;
    } req_t;

    typedef struct packed {
        logic [7:0]  dest;
        logic [1:0]  ack_kind;
        logic [63:0] ack_bytes;
        logic [3:0]  ack_length;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/rrar_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module rrar_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/rrar_engine.sv =====
// Request sequencer: clear pass after reset, byte-serial read/write of the stores.
// Depends on rrar_pkg; drives two rrar_ram instances in the top level.
`default_nettype none

module rrar_engine #(
    parameter int unsigned PATCH_DEPTH    = 512,
    parameter int unsigned ENSEMBLE_DEPTH = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire rrar_pkg::req_t                    req,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output rrar_pkg::result_t                      res,
    output logic                                   patch_we,
    output logic [$clog2(PATCH_DEPTH)-1:0]         patch_addr,
    output logic [7:0]                             patch_wdata,
    input  wire logic [7:0]                        patch_rdata,
    output logic                                   ens_we,
    output logic [$clog2(ENSEMBLE_DEPTH)-1:0]      ens_addr,
    output logic [7:0]                             ens_wdata,
    input  wire logic [7:0]                        ens_rdata
);
    import rrar_pkg::*;

    localparam int unsigned PA_W = $clog2(PATCH_DEPTH);
    localparam int unsigned EA_W = $clog2(ENSEMBLE_DEPTH);
    localparam int unsigned CLR_DEPTH =
        (PATCH_DEPTH > ENSEMBLE_DEPTH) ? PATCH_DEPTH : ENSEMBLE_DEPTH;
    localparam int unsigned CLR_W = $clog2(CLR_DEPTH + 1);

    typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

    state_t            state_reg, state_next;
    logic              clearing_reg, clearing_next;
    logic [CLR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              ens_reg, ens_next;
    logic              rd_reg, rd_next;
    logic              hit_reg, hit_next;
    logic [3:0]        wlen_reg, wlen_next;
    logic [63:0]       wbuf_reg, wbuf_next;
    result_t           res_reg, res_next;

    logic              in_range;
    logic              wr_byte;
    logic              sel_ens;
    logic [7:0]        rd_byte;

    assign in_range = addr_reg < (ens_reg ? ADDR_W'(ENSEMBLE_DEPTH) : ADDR_W'(PATCH_DEPTH));
    assign wr_byte  = (state_reg == RUN) && !rd_reg && (cnt_reg < wlen_reg) && in_range;
    assign sel_ens  = req.control >= ENS_SELECT;
    assign rd_byte  = hit_reg ? (ens_reg ? ens_rdata : patch_rdata) : 8'h00;

    // memory ports: zero sweep during clear, otherwise the running byte address
    always_comb begin
        if (clearing_reg) begin
            patch_we    = clr_cnt_reg < CLR_W'(PATCH_DEPTH);
            patch_addr  = clr_cnt_reg[PA_W-1:0];
            patch_wdata = 8'h00;
            ens_we      = clr_cnt_reg < CLR_W'(ENSEMBLE_DEPTH);
            ens_addr    = clr_cnt_reg[EA_W-1:0];
            ens_wdata   = 8'h00;
        end else begin
            patch_we    = wr_byte && !ens_reg;
            patch_addr  = addr_reg[PA_W-1:0];
            patch_wdata = wbuf_reg[7:0];
            ens_we      = wr_byte && ens_reg;
            ens_addr    = addr_reg[EA_W-1:0];
            ens_wdata   = wbuf_reg[7:0];
        end
    end

    assign req_ready = (state_reg == IDLE) && !clearing_reg;
    assign res_valid = (state_reg == DONE);
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        ens_next      = ens_reg;
        rd_next       = rd_reg;
        hit_next      = hit_reg;
        wlen_next     = wlen_reg;
        wbuf_next     = wbuf_reg;
        res_next      = res_reg;

        if (clearing_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1)) begin
                clearing_next = 1'b0;
            end
        end

        case (state_reg)
            IDLE: begin
                if (req_valid && req_ready) begin
                    ens_next  = sel_ens;
                    addr_next = sel_ens ? ADDR_W'(req.control[7:0]) : ADDR_W'(req.control);
                    wlen_next = (req.length > NBYTES) ? NBYTES : req.length;
                    wbuf_next = req.payload;
                    cnt_next  = 4'd0;
                    hit_next  = 1'b0;
                    rd_next   = 1'b0;
                    res_next.dest       = req.requester;
                    res_next.ack_kind   = KIND_ERROR;
                    res_next.ack_bytes  = 64'h0;
                    res_next.ack_length = 4'd0;
                    state_next = DONE;
                    case (req.cmd)
                        CMD_SPECIAL: res_next.ack_kind = KIND_OK;
                        CMD_READ: begin
                            res_next.ack_kind   = KIND_READ;
                            res_next.ack_length = NBYTES;
                            rd_next    = 1'b1;
                            state_next = RUN;
                        end
                        CMD_WRITE: begin
                            if (req.length != 4'd0) begin
                                res_next.ack_kind = KIND_OK;
                                state_next        = RUN;
                            end
                        end
                        CMD_PING: begin
                            res_next.ack_kind   = KIND_OK;
                            res_next.ack_bytes  = PING_BYTES;
                            res_next.ack_length = NBYTES;
                        end
                        default: res_next.ack_kind = KIND_ERROR;
                    endcase
                end
            end
            RUN: begin
                // issue byte cnt, capture byte cnt-1 from the RAM read register
                addr_next = addr_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                hit_next  = rd_reg && in_range && (cnt_reg < NBYTES);
                wbuf_next = {8'h00, wbuf_reg[63:8]};
                if (rd_reg && cnt_reg != 4'd0) begin
                    res_next.ack_bytes = {rd_byte, res_reg.ack_bytes[63:8]};
                end
                if (cnt_reg == NBYTES) begin
                    state_next = DONE;
                end
            end
            DONE: begin
                if (res_ready) begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
        cnt_reg  <= cnt_next;
        addr_reg <= addr_next;
        ens_reg  <= ens_next;
        rd_reg   <= rd_next;
        hit_reg  <= hit_next;
        wlen_reg <= wlen_next;
        wbuf_reg <= wbuf_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

// ===== rtl/remote_ram_access_responder.sv =====
// Remote RAM access responder top level: stream ports, stores and output register.
// Depends on rrar_pkg, rrar_ram and rrar_engine.
//
// Each request on the s_ channel gets exactly one acknowledge on the m_ channel.
// Request kinds (s_tuser): special, ram read, ram write, ping; others -> error.
// Control >= 0xff00 addresses the ensemble store at control[7:0], otherwise
// the patch store. Out-of-range bytes read as zero and are skipped on writes.
// Reads and writes are byte-serial through single-port RAMs, one byte per
// cycle: such a request keeps the sequencer in its run state, then in its
// done state until the result is handed to the output register that drives
// m_. Special, ping, unknown kinds and zero-length writes skip the run state.
// The next request is taken once the sequencer has handed off its result,
// even if m_tready is low; a stalled receiver backs up only when both the
// sequencer and output register hold one.
// After reset both stores are zeroed by a sweep over max(PATCH_DEPTH,
// ENSEMBLE_DEPTH) addresses (512 by default); s_tready stays low until it ends.
`default_nettype none

module remote_ram_access_responder #(
    parameter int unsigned PATCH_DEPTH    = 512,
    parameter int unsigned ENSEMBLE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // requester[7:0], control[23:8], payload[87:24],
                                        // length[91:88], zero pad
    input  wire logic [2:0]  s_tuser,   // cmd[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // dest[7:0], ack_bytes[71:8], ack_length[75:72],
                                        // zero pad
    output logic [1:0]       m_tuser    // ack_kind[1:0]
);
    import rrar_pkg::*;

    localparam int unsigned PA_W = $clog2(PATCH_DEPTH);
    localparam int unsigned EA_W = $clog2(ENSEMBLE_DEPTH);

    req_t            req;
    result_t         res;
    logic            res_valid;
    logic            res_ready;
    logic            patch_we;
    logic [PA_W-1:0] patch_addr;
    logic [7:0]      patch_wdata;
    logic [7:0]      patch_rdata;
    logic            ens_we;
    logic [EA_W-1:0] ens_addr;
    logic [7:0]      ens_wdata;
    logic [7:0]      ens_rdata;

    logic            out_valid_reg;
    result_t         out_reg;

    assign req.cmd       = s_tuser;
    assign req.requester = s_tdata[7:0];
    assign req.control   = s_tdata[23:8];
    assign req.payload   = s_tdata[87:24];
    assign req.length    = s_tdata[91:88];

    rrar_engine #(
        .PATCH_DEPTH    (PATCH_DEPTH),
        .ENSEMBLE_DEPTH (ENSEMBLE_DEPTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .patch_we    (patch_we),
        .patch_addr  (patch_addr),
        .patch_wdata (patch_wdata),
        .patch_rdata (patch_rdata),
        .ens_we      (ens_we),
        .ens_addr    (ens_addr),
        .ens_wdata   (ens_wdata),
        .ens_rdata   (ens_rdata)
    );

    rrar_ram #(
        .WIDTH (8),
        .DEPTH (PATCH_DEPTH)
    ) u_patch_ram (
        .aclk  (aclk),
        .we    (patch_we),
        .addr  (patch_addr),
        .wdata (patch_wdata),
        .rdata (patch_rdata)
    );

    rrar_ram #(
        .WIDTH (8),
        .DEPTH (ENSEMBLE_DEPTH)
    ) u_ens_ram (
        .aclk  (aclk),
        .we    (ens_we),
        .addr  (ens_addr),
        .wdata (ens_wdata),
        .rdata (ens_rdata)
    );

    // output register: frees the sequencer while the receiver stalls
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.ack_kind;
    assign m_tdata  = {4'h0, out_reg.ack_length, out_reg.ack_bytes, out_reg.dest};

endmodule

`default_nettype wire

// ===== bench/rrar_tb_pkg.sv =====
`timescale 1ns / 1ps
// Acknowledge tracker for the remote RAM access responder bench: shadow stores,
// prediction of each acknowledge and in-order checking. Depends on rrar_pkg.
package rrar_tb_pkg;

    import rrar_pkg::*;

    localparam int unsigned PATCH_BYTES = 512;
    localparam int unsigned ENS_BYTES   = 64;

    // request kinds past ping are all unknown
    localparam logic [2:0] CMD_OTHER_FIRST = CMD_PING + 3'd1;
    localparam logic [2:0] CMD_LAST        = 3'h7;

    class ack_tracker;

        bit [7:0]    patch_mem [PATCH_BYTES];
        bit [7:0]    ens_mem [ENS_BYTES];
        result_t     pending_acks [$];
        int unsigned mismatches;
        int unsigned acks_checked;
        int unsigned n_read, n_write, n_ping, n_other, n_edge;

        task report_mismatch(string what);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        // Work out the acknowledge of one request and apply its store update.
        function result_t predict_ack(req_t r);
            result_t     a;
            bit          ens;
            int unsigned base, depth, len, addr;
            a.dest       = r.requester;
            a.ack_kind   = KIND_ERROR;
            a.ack_bytes  = '0;
            a.ack_length = '0;
            ens   = (r.control >= ENS_SELECT);
            base  = ens ? int'(r.control[7:0]) : int'(r.control);
            depth = ens ? ENS_BYTES : PATCH_BYTES;
            len   = (r.length > NBYTES) ? NBYTES : r.length;
            case (r.cmd)
                CMD_SPECIAL: begin
                    a.ack_kind = KIND_OK;
                    n_other++;
                end
                CMD_READ: begin
                    for (int i = 0; i < NBYTES; i++) begin
                        addr = base + i;
                        if (addr < depth)
                            a.ack_bytes[8*i +: 8] = ens ? ens_mem[addr] : patch_mem[addr];
                    end
                    a.ack_kind   = KIND_READ;
                    a.ack_length = NBYTES;
                    n_read++;
                    if (base + NBYTES > depth) n_edge++;
                end
                CMD_WRITE: begin
                    // zero length stores nothing and is refused
                    if (len != 0) begin
                        for (int i = 0; i < len; i++) begin
                            addr = base + i;
                            if (addr < depth) begin
                                if (ens) ens_mem[addr] = r.payload[8*i +: 8];
                                else     patch_mem[addr] = r.payload[8*i +: 8];
                            end
                        end
                        a.ack_kind = KIND_OK;
                        if (base + len > depth) n_edge++;
                    end
                    n_write++;
                end
                CMD_PING: begin
                    // version 1, node type "SID ", node version 2, subversion 0
                    a.ack_bytes  = {16'h0000, 8'd2, " ", "D", "I", "S", 8'd1};
                    a.ack_kind   = KIND_OK;
                    a.ack_length = NBYTES;
                    n_ping++;
                end
                default: n_other++;
            endcase
            return a;
        endfunction

        function void note_request(req_t r);
            pending_acks.push_back(predict_ack(r));
        endfunction

        function int unsigned pending();
            return pending_acks.size();
        endfunction

        task check_ack(result_t got);
            result_t want;
            acks_checked++;
            if (pending_acks.size() == 0) begin
                report_mismatch($sformatf("ack to node %0d with no request outstanding",
                                          got.dest));
                return;
            end
            want = pending_acks.pop_front();
            if (got.dest != want.dest)
                report_mismatch($sformatf("dest %0h, want %0h", got.dest, want.dest));
            if (got.ack_kind != want.ack_kind)
                report_mismatch($sformatf("node %0h: kind %0d, want %0d",
                                          want.dest, got.ack_kind, want.ack_kind));
            if (got.ack_bytes != want.ack_bytes)
                report_mismatch($sformatf("node %0h: bytes %h, want %h",
                                          want.dest, got.ack_bytes, want.ack_bytes));
            if (got.ack_length != want.ack_length)
                report_mismatch($sformatf("node %0h: length %0d, want %0d",
                                          want.dest, got.ack_length, want.ack_length));
        endtask

    endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the remote RAM access responder bench: clock, reset, request driver,
// acknowledge receiver and monitor. Depends on rrar_pkg, rrar_tb_pkg and the RTL.
module tb_top;

    import rrar_pkg::*;
    import rrar_tb_pkg::*;

    localparam int unsigned RANDOM_REQS  = 400;
    localparam int unsigned HOLD_CYCLES  = 80;     // long receiver hold-off
    localparam int unsigned TAIL_CYCLES  = 40;     // idle tail after the final drain
    localparam int unsigned LIMIT_CYCLES = 200_000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    ack_tracker  tracker = new();
    bit          steady;      // no idling on either side while set
    bit          hold_req;    // asks the receiver for a long hold-off
    int unsigned cycles;

    remote_ram_access_responder #(
        .PATCH_DEPTH   (PATCH_BYTES),
        .ENSEMBLE_DEPTH(ENS_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Watchdog; the store-clearing sweep after reset is well inside the limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d acks outstanding",
                     cycles, tracker.pending());
            $display("[remote_ram_access_responder] ERROR");
            $finish;
        end
    end

    // Acknowledge monitor: sampled at the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_ack('{dest:       m_tdata[7:0],
                                ack_kind:   m_tuser,
                                ack_bytes:  m_tdata[71:8],
                                ack_length: m_tdata[75:72]});
    end

    // Receiver: random back-pressure, plus a counted hold-off on request.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 36);
            end
        end
    end

    function automatic req_t mk_req(logic [2:0] cmd, logic [7:0] node, logic [15:0] ctrl,
                                    logic [63:0] data, logic [3:0] len);
        req_t r;
        r.cmd       = cmd;
        r.requester = node;
        r.control   = ctrl;
        r.payload   = data;
        r.length    = len;
        return r;
    endfunction

    // Mostly reads and writes around a few hot windows so reads see earlier
    // writes; store ends, ensemble selection and stray addresses mixed in.
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick, where;
        r.requester = 8'($urandom_range(255));
        r.payload   = {$urandom, $urandom};
        r.length    = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 42)      r.cmd = CMD_WRITE;
        else if (pick < 80) r.cmd = CMD_READ;
        else if (pick < 87) r.cmd = CMD_PING;
        else if (pick < 93) r.cmd = CMD_SPECIAL;
        else                r.cmd = 3'($urandom_range(CMD_LAST, CMD_OTHER_FIRST));
        where = $urandom_range(99);
        if (where < 45)      r.control = 16'($urandom_range(63));
        else if (where < 60) r.control = 16'($urandom_range(PATCH_BYTES - 1, PATCH_BYTES - 12));
        else if (where < 85) r.control = ENS_SELECT + 16'($urandom_range(ENS_BYTES + 7));
        else                 r.control = 16'($urandom);
        if (r.cmd == CMD_WRITE) begin
            // lengths above eight and zero stay in the remaining share
            pick = $urandom_range(99);
            if (pick < 80)      r.length = 4'($urandom_range(NBYTES, 1));
            else if (pick < 88) r.length = '0;
        end
        return r;
    endfunction

    // One request: random idle cycles first, then hold it until accepted.
    task automatic send_request(input req_t r);
        while (!steady && $urandom_range(99) < 36) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {4'h0, r.length, r.payload, r.control, r.requester};
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(r);
    endtask

    // Sender pause until every acknowledge is back.
    task automatic drain_acks();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        req_t directed [$];
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: every kind, field extremes, store ends, length saturation.
        directed.push_back(mk_req(CMD_PING,        8'h00, 16'h0000, 64'h0, 4'h0));
        directed.push_back(mk_req(CMD_SPECIAL,     8'hff, 16'hffff, '1, 4'hf));
        directed.push_back(mk_req(CMD_OTHER_FIRST, 8'h12, 16'h0010, 64'h0, 4'h8));
        directed.push_back(mk_req(CMD_LAST,        8'hff, 16'hff00, '1, 4'h8));
        directed.push_back(mk_req(CMD_WRITE,       8'h01, 16'h0000, '1, 4'h0));
        directed.push_back(mk_req(CMD_WRITE,       8'h02, 16'h0000,
                                  64'h0123_4567_89ab_cdef, 4'h8));
        directed.push_back(mk_req(CMD_READ,        8'h03, 16'h0000, 64'h0, 4'h0));
        // length 15 saturates to 8; bytes past the patch end are dropped
        directed.push_back(mk_req(CMD_WRITE,       8'h04, 16'd508, '1, 4'hf));
        directed.push_back(mk_req(CMD_READ,        8'h05, 16'd506, 64'h0, 4'h0));
        directed.push_back(mk_req(CMD_READ,        8'h06, 16'hfeff, 64'h0, 4'h0));
        directed.push_back(mk_req(CMD_WRITE,       8'h07, 16'hfeff, '1, 4'h8));
        // ensemble store, crossing its end
        directed.push_back(mk_req(CMD_WRITE,       8'h08, 16'hff3c,
                                  64'hfedc_ba98_7654_3210, 4'h8));
        directed.push_back(mk_req(CMD_READ,        8'h09, 16'hff3c, 64'h0, 4'h0));
        directed.push_back(mk_req(CMD_WRITE,       8'h0a, 16'hffff, '1, 4'h1));
        directed.push_back(mk_req(CMD_READ,        8'h0b, 16'hffff, 64'h0, 4'h0));
        directed.push_back(mk_req(CMD_WRITE,       8'h0c, 16'hff00,
                                  64'h0000_0000_00c3_b2a1, 4'h3));
        directed.push_back(mk_req(CMD_READ,        8'h0d, 16'hff00, '1, 4'hf));
        directed.push_back(mk_req(CMD_WRITE,       8'h0e, 16'd511, 64'h5a, 4'h1));
        directed.push_back(mk_req(CMD_READ,        8'h0f, 16'd504, 64'h0, 4'h0));
        directed.push_back(mk_req(CMD_PING,        8'ha5, 16'h5a5a, '1, 4'hf));
        directed.push_back(mk_req(CMD_WRITE,       8'h10, 16'd100,
                                  64'h8899_aabb_ccdd_eeff, 4'h9));
        directed.push_back(mk_req(CMD_READ,        8'h11, 16'd100, 64'h0, 4'h0));
        foreach (directed[i]) send_request(directed[i]);
        drain_acks();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            steady = (n >= 150 && n < 230);
            if (n == 100) hold_req = 1'b1;   // receiver stalls, requests keep coming
            if (n == 260) drain_acks();
            send_request(random_request());
        end
        drain_acks();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d requests: %0d reads, %0d writes, %0d pings, %0d special or unknown",
                 tracker.n_read + tracker.n_write + tracker.n_ping + tracker.n_other,
                 tracker.n_read, tracker.n_write, tracker.n_ping, tracker.n_other);
        $display("%0d acks checked, %0d accesses ran past a store end, %0d mismatches",
                 tracker.acks_checked, tracker.n_edge, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("[remote_ram_access_responder] OK");
        else
            $display("[remote_ram_access_responder] ERROR");
        $finish;
    end

endmodule
